// File: rtl/core/dstrc_pkg.sv
// Shared constants and types for the daylight saving rule checker.
// No dependencies; used by dstrc_sunday and dst_rule_checker.
package dstrc_pkg;

  // Months that carry a switch day
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  // Clock change happens at this standard hour
  localparam logic [4:0] SWITCH_HOUR = 5'd2;

  // UTC offsets in seconds, two's complement
  localparam logic signed [15:0] STD_OFFSET = -16'sd18000;
  localparam logic signed [15:0] DST_OFFSET = -16'sd14400;

  // Weekday key per month, January first
  localparam logic [2:0] MONTH_KEY [12] = '{
    3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
  };

  // Reciprocal for divide by 100, exact for any 14-bit year
  localparam int          DIV100_SHIFT = 19;
  localparam logic [12:0] DIV100_MUL   = 13'd5243;

  // Date fields carried down the pipeline beside the weekday math
  typedef struct packed {
    logic       is_mar;
    logic       is_nov;
    logic       mid;     // April to October
    logic [4:0] day;
    logic [4:0] hour;
  } date_info_t;

endpackage

// File: rtl/core/dstrc_sunday.sv
// Three-stage pipeline giving the day of month of the first Sunday of
// March or November for a given year. Depends on dstrc_pkg.
module dstrc_sunday (
  input  logic        clk,
  input  logic        en,            // advance all stages
  input  logic [13:0] year,
  input  logic        is_nov,
  output logic [2:0]  first_sunday   // 1..7, valid once the year has passed stages A, B and C
);

  localparam logic [26:0] DIV100_MUL_EXT = 27'(dstrc_pkg::DIV100_MUL);

  // Stage A registers
  logic [13:0] year_a;
  logic [26:0] prod_a;
  logic [2:0]  key_a;

  // Stage B register
  logic [14:0] sum_b;

  // Stage C register
  logic [5:0]  dig_c;

  logic [7:0]  q100;
  logic [14:0] sum_next;
  logic [5:0]  dig_next;
  logic [3:0]  fold;
  logic [2:0]  wday;

  // Stage A: multiply by reciprocal of 100, pick month key
  always_ff @(posedge clk) begin
    if (en) begin
      year_a <= year;
      prod_a <= 27'(year * DIV100_MUL_EXT);
      key_a  <= is_nov ? dstrc_pkg::MONTH_KEY[10] : dstrc_pkg::MONTH_KEY[2];
    end
  end

  // Stage B: Sakamoto sum for the first day of the month
  assign q100     = prod_a[dstrc_pkg::DIV100_SHIFT +: 8];
  assign sum_next = 15'(year_a) + 15'(year_a >> 2) - 15'(q100) + 15'(q100 >> 2)
                  + 15'(key_a) + 15'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_b <= sum_next;
    end
  end

  // Stage C: fold octal digits, since 8 is 1 mod 7
  assign dig_next = 6'(sum_b[2:0]) + 6'(sum_b[5:3]) + 6'(sum_b[8:6])
                  + 6'(sum_b[11:9]) + 6'(sum_b[14:12]);

  always_ff @(posedge clk) begin
    if (en) begin
      dig_c <= dig_next;
    end
  end

  // Finish mod 7 and turn weekday into first Sunday
  assign fold = 4'(dig_c[2:0]) + 4'(dig_c[5:3]);

  always_comb begin
    if (fold >= 4'd14) begin
      wday = 3'(fold - 4'd14);
    end else if (fold >= 4'd7) begin
      wday = 3'(fold - 4'd7);
    end else begin
      wday = fold[2:0];
    end
    first_sunday = (wday == 3'd0) ? 3'd1 : 3'(4'd8 - 4'(wday));
  end

endmodule

// File: rtl/core/dst_rule_checker.sv
// Top level of the daylight saving rule checker: input/output beats,
// date pipeline and offset register. Depends on dstrc_pkg, dstrc_sunday.
//
// Usage: each input beat carries one local date and standard hour; each
// output beat carries the DST flag and the UTC offset in seconds (-5 h,
// or -4 h when DST is in force and dst_enable is set).
// Channels: s_tvalid/s_tready/s_tdata in, m_tvalid/m_tready/m_tdata out,
// one output beat per input beat, in order.
// Pipeline: an accepted input beat passes three stages of weekday math,
// then the compare and offset register, before its output beat.
// Throughput: one beat per cycle while m_tready is high.
// Stall: when m_tready is low with a beat waiting, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
// Reset: rst clears all valid bits and sets dst_enable to 1.
// Configuration: cfg_wr writes cfg_wdata into dst_enable; write only
// while no beat is in flight.
module dst_rule_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic        cfg_wdata,   // dst_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // year[13:0], month[17:14], day[22:18], hour[27:23]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata      // in_dst[0], utc_offset_seconds[16:1]
);

  logic        dst_enable;
  logic        adv;
  logic        v1, v2, v3;
  logic        in_dst;
  logic signed [15:0] utc_offset_seconds;

  logic [13:0] year;
  logic [3:0]  month;
  dstrc_pkg::date_info_t info_next, info1, info2, info3;
  logic [2:0]  first_sunday;
  logic [4:0]  sw_day;
  logic        dst_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_enable <= 1'b1;
    end else if (cfg_wr) begin
      dst_enable <= cfg_wdata;
    end
  end

  // Advance every stage when the output register is free
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Unpack the input beat and classify the month
  assign year  = s_tdata[13:0];
  assign month = s_tdata[17:14];

  always_comb begin
    info_next.is_mar = (month == dstrc_pkg::MONTH_MAR);
    info_next.is_nov = (month == dstrc_pkg::MONTH_NOV);
    info_next.mid    = (month > dstrc_pkg::MONTH_MAR) && (month < dstrc_pkg::MONTH_NOV);
    info_next.day    = s_tdata[22:18];
    info_next.hour   = s_tdata[27:23];
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  // Date fields follow the weekday pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      info1 <= info_next;
      info2 <= info1;
      info3 <= info2;
    end
  end

  dstrc_sunday u_sunday (
    .clk          (clk),
    .en           (adv),
    .year         (year),
    .is_nov       (info_next.is_nov),
    .first_sunday (first_sunday)
  );

  // Switch day: second Sunday of March, first Sunday of November
  assign sw_day = info3.is_mar ? 5'(first_sunday) + 5'd7 : 5'(first_sunday);

  always_comb begin
    dst_next = info3.mid
      || (info3.is_mar && ((info3.day > sw_day)
          || ((info3.day == sw_day) && (info3.hour >= dstrc_pkg::SWITCH_HOUR))))
      || (info3.is_nov && ((info3.day < sw_day)
          || ((info3.day == sw_day) && (info3.hour < dstrc_pkg::SWITCH_HOUR))));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      in_dst             <= dst_next;
      utc_offset_seconds <= (dst_next && dst_enable) ? dstrc_pkg::DST_OFFSET
                                                     : dstrc_pkg::STD_OFFSET;
    end
  end

  assign m_tdata = {7'd0, utc_offset_seconds, in_dst};

  // Accepted input beat shows up in the first stage
  a_accept_to_v1: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted beat missing from first stage");

  // A stalled third stage keeps its beat
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !adv |=> v3)
    else $error("stalled beat lost");

  // A valid output's offset is only ever one of the two legal values
  a_offset_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (utc_offset_seconds == dstrc_pkg::STD_OFFSET)
              || (utc_offset_seconds == dstrc_pkg::DST_OFFSET))
    else $error("illegal offset");

  // Outside DST the offset is standard time
  a_std_when_no_dst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !in_dst |-> utc_offset_seconds == dstrc_pkg::STD_OFFSET)
    else $error("daylight offset without DST");

endmodule

// File: dv/tb_dst_rule_checker.sv
`timescale 1ns / 1ps
// Self-checking testbench for dst_rule_checker: directed extremes and dates
// near switch Sundays, then random date phases under sender and receiver idling.
// Depends on dstrc_pkg and the dst_rule_checker RTL.
module tb_dst_rule_checker;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned HOLD_BEATS    = 40;
  localparam int unsigned PHASE_BEATS   = 475;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned DRAIN_CYCLES  = 10;

  // Predictor constants: standard offset and daylight shift in seconds
  localparam int STD_SECONDS      = -18000;
  localparam int DAYLIGHT_SECONDS = 3600;
  // Weekday keys of the two switch months and which Sunday switches
  localparam int unsigned MAR_KEY = 2;
  localparam int unsigned NOV_KEY = 2;
  localparam int unsigned MAR_NTH = 2;
  localparam int unsigned NOV_NTH = 1;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  // Fields ordered high to low so that {pad, date} matches the tdata layout
  typedef struct packed {
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_t;

  typedef struct packed {
    logic              in_dst;
    logic signed [15:0] utc_offset;
  } dst_verdict_t;

  typedef struct {
    date_t        date;
    bit           typed;
    dst_verdict_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;     // year[13:0], month[17:14], day[22:18], hour[27:23]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // in_dst[0], utc_offset_seconds[16:1]

  dst_verdict_t verdict_queue[$];
  dst_verdict_t arrived_want;
  plan_row_t    directed_plan[$];
  bit           dst_enable_shadow = 1'b1;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  hold_reqs = 0;
  int unsigned  errors = 0;
  int unsigned  cycle_count = 0;

  dst_rule_checker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Day of month of the switch Sunday in March or November
  function automatic int unsigned switch_sunday(int unsigned yr, logic [3:0] mon);
    int unsigned key;
    int unsigned nth;
    int unsigned first;
    key   = (mon == dstrc_pkg::MONTH_MAR) ? MAR_KEY : NOV_KEY;
    nth   = (mon == dstrc_pkg::MONTH_MAR) ? MAR_NTH : NOV_NTH;
    first = (yr + yr / 4 - yr / 100 + yr / 400 + key + 1) % 7;
    return 1 + (7 - first) % 7 + (nth - 1) * 7;
  endfunction

  // Expected DST flag and offset for one date under the given enable
  function automatic dst_verdict_t dst_verdict(date_t d, bit enable);
    dst_verdict_t r;
    int unsigned  sw;
    if (d.month < dstrc_pkg::MONTH_MAR || d.month > dstrc_pkg::MONTH_NOV) begin
      r.in_dst = 1'b0;
    end else if (d.month != dstrc_pkg::MONTH_MAR && d.month != dstrc_pkg::MONTH_NOV) begin
      r.in_dst = 1'b1;
    end else begin
      sw = switch_sunday(d.year, d.month);
      if (d.month == dstrc_pkg::MONTH_MAR)
        r.in_dst = (d.day > sw) || (d.day == sw && d.hour >= dstrc_pkg::SWITCH_HOUR);
      else
        r.in_dst = (d.day < sw) || (d.day == sw && d.hour < dstrc_pkg::SWITCH_HOUR);
    end
    r.utc_offset = 16'(STD_SECONDS + ((r.in_dst && enable) ? DAYLIGHT_SECONDS : 0));
    return r;
  endfunction

  // Random date, weighted toward the days and hours around the switches
  function automatic date_t random_date();
    date_t       d;
    int unsigned pick;
    int unsigned sw;
    pick   = $urandom_range(99);
    d.year = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(9999, 1));
    if (pick < 35)      d.month = dstrc_pkg::MONTH_MAR;
    else if (pick < 70) d.month = dstrc_pkg::MONTH_NOV;
    else                d.month = 4'($urandom);
    if ((d.month == dstrc_pkg::MONTH_MAR || d.month == dstrc_pkg::MONTH_NOV)
        && $urandom_range(9) < 7) begin
      sw    = switch_sunday(d.year, d.month);
      d.day = 5'(sw + $urandom_range(2) - 1);
    end else begin
      d.day = 5'($urandom);
    end
    d.hour = ($urandom_range(9) < 6) ? 5'($urandom_range(3)) : 5'($urandom);
    return d;
  endfunction

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  task automatic add_row(input int unsigned yr, input int unsigned mon,
                         input int unsigned dom, input int unsigned hr,
                         input bit typed, input bit dst, input int off);
    plan_row_t row;
    row.date.year        = 14'(yr);
    row.date.month       = 4'(mon);
    row.date.day         = 5'(dom);
    row.date.hour        = 5'(hr);
    row.typed            = typed;
    row.want.in_dst      = dst;
    row.want.utc_offset  = 16'(off);
    directed_plan.push_back(row);
  endtask

  // Offer one date, record its verdict on acceptance, then maybe go idle
  task automatic send_date(input date_t d, input bit typed, input dst_verdict_t typed_want);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, d};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    verdict_queue.push_back(typed ? typed_want : dst_verdict(d, dst_enable_shadow));
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop valid and hold until every outstanding verdict has arrived
  task automatic wait_empty();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_enable(input bit value);
    cfg_wr    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr    <= 1'b0;
    dst_enable_shadow = value;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != served) begin
        served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check each output beat against the oldest verdict
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_queue.size() == 0) begin
        note_failure($sformatf("output beat with nothing expected: tdata=%h", m_tdata));
      end else begin
        arrived_want = verdict_queue.pop_front();
        if (m_tdata[0] !== arrived_want.in_dst)
          note_failure($sformatf("in_dst mismatch: expected %0d, got %0d",
                                 arrived_want.in_dst, m_tdata[0]));
        if ($signed(m_tdata[16:1]) !== arrived_want.utc_offset)
          note_failure($sformatf("utc_offset mismatch: expected %0d, got %0d",
                                 arrived_want.utc_offset, $signed(m_tdata[16:1])));
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dst_rule_checker regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned  phase_idle[4];
    int unsigned  phase_stall[4];
    bit           phase_enable[4];
    dst_verdict_t none;

    phase_idle   = '{0, 63, 0, 34};
    phase_stall  = '{0, 0, 63, 34};
    phase_enable = '{1'b0, 1'b1, 1'b0, 1'b1};
    none         = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Extremes and months that never or always switch, typed in directly
    add_row(1, 1, 1, 0, TYPED, 1'b0, -18000);
    add_row(9999, 12, 31, 23, TYPED, 1'b0, -18000);
    add_row(16383, 7, 31, 31, TYPED, 1'b1, -14400);
    add_row(0, 0, 0, 0, TYPED, 1'b0, -18000);
    add_row(2024, 13, 15, 10, TYPED, 1'b0, -18000);
    add_row(16383, 15, 31, 31, TYPED, 1'b0, -18000);
    add_row(2024, 4, 1, 0, TYPED, 1'b1, -14400);
    add_row(2024, 10, 31, 23, TYPED, 1'b1, -14400);
    add_row(2024, 2, 29, 12, TYPED, 1'b0, -18000);
    // Switch days and their neighbors, odd days and hours, odd years
    add_row(2024, 3, 10, 1, PREDICTED, 1'b0, 0);
    add_row(2024, 3, 10, 2, PREDICTED, 1'b0, 0);
    add_row(2024, 3, 9, 23, PREDICTED, 1'b0, 0);
    add_row(2024, 3, 11, 0, PREDICTED, 1'b0, 0);
    add_row(2024, 11, 3, 1, PREDICTED, 1'b0, 0);
    add_row(2024, 11, 3, 2, PREDICTED, 1'b0, 0);
    add_row(2024, 11, 2, 23, PREDICTED, 1'b0, 0);
    add_row(2024, 11, 4, 0, PREDICTED, 1'b0, 0);
    add_row(2024, 3, 0, 5, PREDICTED, 1'b0, 0);
    add_row(2024, 11, 0, 0, PREDICTED, 1'b0, 0);
    add_row(2024, 3, 31, 24, PREDICTED, 1'b0, 0);
    add_row(0, 3, 8, 31, PREDICTED, 1'b0, 0);
    add_row(16383, 11, 31, 0, PREDICTED, 1'b0, 0);
    add_row(2000, 3, 12, 2, PREDICTED, 1'b0, 0);
    add_row(1900, 11, 4, 1, PREDICTED, 1'b0, 0);

    foreach (directed_plan[i])
      send_date(directed_plan[i].date, directed_plan[i].typed, directed_plan[i].want);
    wait_empty();

    // Random phases, each behind a fresh enable setting
    for (int p = 0; p < 4; p++) begin
      write_enable(phase_enable[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      // Back up the pipeline behind a long receiver hold-off
      if (p == 0) begin
        hold_reqs++;
        for (int n = 0; n < HOLD_BEATS; n++) send_date(random_date(), PREDICTED, none);
      end
      for (int n = 0; n < PHASE_BEATS; n++) send_date(random_date(), PREDICTED, none);
      wait_empty();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_queue.size() != 0)
      note_failure($sformatf("%0d verdicts never arrived", verdict_queue.size()));
    if (errors == 0)
      $display("dst_rule_checker regression: pass");
    else
      $display("dst_rule_checker regression: fail");
    $finish;
  end

endmodule

// File: dst_rule_checker.f
rtl/core/dstrc_pkg.sv
rtl/core/dstrc_sunday.sv
rtl/core/dst_rule_checker.sv
dv/tb_dst_rule_checker.sv
